// ----- design/drpk_pkg.sv -----
// Package for the DER RSA public key locator: parse phases, codes and widths.
package drpk_pkg;

	localparam int PosW = 17;
	localparam int LenW = 16;

	localparam logic [7:0] TagInteger  = 8'h02;
	localparam logic [7:0] TagSequence = 8'h30;
	localparam logic [7:0] LenOneByte  = 8'h81;
	localparam logic [7:0] LenTwoBytes = 8'h82;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_TAG = 2'd1,
		ST_BAD_LEN = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_SEQ_LEN  = 4'd1,
		PH_SEQ_EXT  = 4'd2,
		PH_MOD_TAG  = 4'd3,
		PH_MOD_LEN  = 4'd4,
		PH_MOD_EXT  = 4'd5,
		PH_MOD_SKIP = 4'd6,
		PH_EXP_TAG  = 4'd7,
		PH_EXP_LEN  = 4'd8,
		PH_EXP_EXT  = 4'd9,
		PH_DONE     = 4'd10
	} phase_t;

	typedef enum logic [0:0] {
		REG_PART_SELECT = 1'd0
	} reg_index_t;

endpackage

// ----- design/der_rsa_pubkey_locator.sv -----
// Top level: byte-stream parser that locates the modulus or exponent of a DER RSA key.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | in        | in_valid / in_ready | data_byte[7:0], first
//  out     | out       | out_valid/out_ready | status[1:0], part_offset[16:0],
//          |           |                     | part_length[15:0]
//  cfg     | in        | APB, pready = 1     | reg 0 part_select at byte address 0
//
// One byte per cycle sustained unless the result stalls. A byte is held in the input
// register, is parsed by the phase logic and any result is loaded into the output register.
// Asynchronous reset clears the parse state, valid bits and part_select.
// A stalled result holds the input register; the input side keeps taking bytes while the
// result register is free or being drained in the same cycle.
module der_rsa_pubkey_locator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [16:0] part_offset,
	output logic [15:0] part_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PosW = drpk_pkg::PosW;
	localparam int LenW = drpk_pkg::LenW;

	logic part_select_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;

	drpk_pkg::phase_t phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [LenW-1:0] accum_q, accum_d;
	logic [1:0]      left_q, left_d;
	logic [LenW-1:0] skip_q, skip_d;
	logic [PosW-1:0] mod_off_q, mod_off_d;
	logic [LenW-1:0] mod_len_q, mod_len_d;

	logic              emit;
	drpk_pkg::status_t emit_status;
	logic [PosW-1:0]   emit_off;
	logic [LenW-1:0]   emit_len;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [PosW-1:0] off_q;
	logic [LenW-1:0] len_q;

	// length field decode
	logic            ls_done, ls_bad;
	logic [LenW-1:0] ls_accum;
	logic [1:0]      ls_left;
	logic [LenW-1:0] ex_accum;
	logic [1:0]      ex_left;
	logic            ex_done;
	logic            lf_done, lf_bad;
	logic [LenW-1:0] lf_accum;
	logic [1:0]      lf_left;
	logic            is_start;
	logic [PosW-1:0] pos_next;

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == drpk_pkg::REG_PART_SELECT)
			prdata[0] = part_select_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_select_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == drpk_pkg::REG_PART_SELECT) begin
			part_select_q <= pwdata[0];
		end
	end

	// input register
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			first_s1 <= first;
		end
	end

	always_comb begin
		ls_done  = !byte_s1[7];
		ls_bad   = byte_s1[7] && byte_s1 != drpk_pkg::LenOneByte
			&& byte_s1 != drpk_pkg::LenTwoBytes;
		ls_accum = byte_s1[7] ? '0 : {{(LenW-8){1'b0}}, byte_s1};
		ls_left  = (byte_s1 == drpk_pkg::LenOneByte) ? 2'd1 :
			(byte_s1 == drpk_pkg::LenTwoBytes) ? 2'd2 : 2'd0;
		ex_accum = {accum_q[LenW-9:0], byte_s1};
		ex_left  = left_q - 2'd1;
		ex_done  = ex_left == 2'd0;
		is_start = phase_q == drpk_pkg::PH_SEQ_LEN || phase_q == drpk_pkg::PH_MOD_LEN
			|| phase_q == drpk_pkg::PH_EXP_LEN;
		lf_done  = is_start ? ls_done : ex_done;
		lf_bad   = is_start && ls_bad;
		lf_accum = is_start ? ls_accum : ex_accum;
		lf_left  = is_start ? ls_left : ex_left;
		pos_next = pos_q + PosW'(1);
	end

	// parse step
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		accum_d     = accum_q;
		left_d      = left_q;
		skip_d      = skip_q;
		mod_off_d   = mod_off_q;
		mod_len_d   = mod_len_q;
		emit        = 1'b0;
		emit_status = drpk_pkg::ST_OK;
		emit_off    = '0;
		emit_len    = '0;
		if (first_s1) begin
			pos_d     = PosW'(1);
			accum_d   = '0;
			left_d    = '0;
			skip_d    = '0;
			mod_off_d = '0;
			mod_len_d = '0;
			phase_d   = drpk_pkg::PH_SEQ_LEN;
			if (byte_s1 != drpk_pkg::TagSequence) begin
				emit        = 1'b1;
				emit_status = drpk_pkg::ST_BAD_TAG;
			end
		end else if (phase_q != drpk_pkg::PH_IDLE && phase_q < drpk_pkg::PH_DONE) begin
			pos_d = pos_next;
			case (phase_q)
				drpk_pkg::PH_SEQ_LEN, drpk_pkg::PH_SEQ_EXT,
				drpk_pkg::PH_MOD_LEN, drpk_pkg::PH_MOD_EXT,
				drpk_pkg::PH_EXP_LEN, drpk_pkg::PH_EXP_EXT: begin
					if (lf_bad) begin
						emit        = 1'b1;
						emit_status = drpk_pkg::ST_BAD_LEN;
					end else begin
						accum_d = lf_accum;
						left_d  = lf_left;
						if (phase_q == drpk_pkg::PH_SEQ_LEN || phase_q == drpk_pkg::PH_SEQ_EXT) begin
							phase_d = lf_done ? drpk_pkg::PH_MOD_TAG : drpk_pkg::PH_SEQ_EXT;
						end else if (phase_q == drpk_pkg::PH_MOD_LEN
							|| phase_q == drpk_pkg::PH_MOD_EXT) begin
							if (!lf_done) begin
								phase_d = drpk_pkg::PH_MOD_EXT;
							end else begin
								mod_off_d = pos_next;
								mod_len_d = lf_accum;
								skip_d    = lf_accum;
								phase_d   = (lf_accum == '0) ? drpk_pkg::PH_EXP_TAG
									: drpk_pkg::PH_MOD_SKIP;
							end
						end else begin
							if (!lf_done) begin
								phase_d = drpk_pkg::PH_EXP_EXT;
							end else begin
								emit     = 1'b1;
								emit_off = part_select_q ? mod_off_q : pos_next;
								emit_len = part_select_q ? mod_len_q : lf_accum;
							end
						end
					end
				end
				drpk_pkg::PH_MOD_TAG, drpk_pkg::PH_EXP_TAG: begin
					if (byte_s1 != drpk_pkg::TagInteger) begin
						emit        = 1'b1;
						emit_status = drpk_pkg::ST_BAD_TAG;
					end else begin
						phase_d = (phase_q == drpk_pkg::PH_MOD_TAG) ? drpk_pkg::PH_MOD_LEN
							: drpk_pkg::PH_EXP_LEN;
					end
				end
				drpk_pkg::PH_MOD_SKIP: begin
					skip_d = skip_q - LenW'(1);
					if (skip_q == LenW'(1))
						phase_d = drpk_pkg::PH_EXP_TAG;
				end
				default: begin
					phase_d = drpk_pkg::PH_DONE;
				end
			endcase
		end
		if (emit)
			phase_d = drpk_pkg::PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= drpk_pkg::PH_IDLE;
			pos_q     <= '0;
			accum_q   <= '0;
			left_q    <= '0;
			skip_q    <= '0;
			mod_off_q <= '0;
			mod_len_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			accum_q   <= accum_d;
			left_q    <= left_d;
			skip_q    <= skip_d;
			mod_off_q <= mod_off_d;
			mod_len_q <= mod_len_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			status_q <= emit_status;
			off_q    <= emit_off;
			len_q    <= emit_len;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign part_offset = off_q;
	assign part_length = len_q;

endmodule

// ----- tb/der_rsa_pubkey_locator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the DER RSA public key locator: random and directed key blobs.
module der_rsa_pubkey_locator_tb;

	localparam logic [7:0] LenIndefinite = 8'h80;
	localparam int unsigned QuietLimit = 4000;
	localparam int unsigned PhaseItems = 238;

	typedef enum logic [1:0] {
		LEN_MORE,
		LEN_DONE,
		LEN_BAD
	} len_step_t;

	typedef struct packed {
		drpk_pkg::status_t st;
		logic [16:0]       off;
		logic [15:0]       len;
	} loc_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       f;
		logic       drain;
	} key_byte_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        first = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [16:0] part_offset;
	logic [15:0] part_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	der_rsa_pubkey_locator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first       (first),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.part_offset (part_offset),
		.part_length (part_length),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// parser shadow state
	drpk_pkg::phase_t walk_phase = drpk_pkg::PH_IDLE;
	logic [16:0] walk_pos = '0;
	logic [15:0] len_acc = '0;
	logic [1:0]  len_left = '0;
	logic [15:0] skip_left = '0;
	logic [16:0] mod_off = '0;
	logic [15:0] mod_len = '0;
	logic        sel_shadow = 1'b0;

	key_byte_t   pend_q[$];
	loc_result_t located_q[$];
	logic [7:0]  blob_q[$];
	int unsigned marks[6];
	int unsigned items_sent = 0;
	int unsigned pending_cnt = 0;
	int unsigned err_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic len_step_t len_head(input logic [7:0] b);
		if (!b[7]) begin
			len_acc = 16'(b);
			len_left = 2'd0;
			return LEN_DONE;
		end
		if (b == drpk_pkg::LenOneByte) begin
			len_acc = '0;
			len_left = 2'd1;
			return LEN_MORE;
		end
		if (b == drpk_pkg::LenTwoBytes) begin
			len_acc = '0;
			len_left = 2'd2;
			return LEN_MORE;
		end
		return LEN_BAD;
	endfunction

	function automatic len_step_t len_tail(input logic [7:0] b);
		len_acc = {len_acc[7:0], b};
		len_left = len_left - 2'd1;
		return (len_left == 2'd0) ? LEN_DONE : LEN_MORE;
	endfunction

	function automatic bit locate_step(input logic [7:0] b, input logic fst,
			output loc_result_t res);
		logic [16:0] nxt;
		len_step_t r;
		bit hit;
		hit = 1'b0;
		res.st = drpk_pkg::ST_OK;
		res.off = '0;
		res.len = '0;
		if (fst) begin
			walk_pos = 17'd1;
			len_acc = '0;
			len_left = '0;
			skip_left = '0;
			mod_off = '0;
			mod_len = '0;
			walk_phase = drpk_pkg::PH_SEQ_LEN;
			if (b != drpk_pkg::TagSequence) begin
				res.st = drpk_pkg::ST_BAD_TAG;
				hit = 1'b1;
			end
		end else if (walk_phase != drpk_pkg::PH_IDLE && walk_phase != drpk_pkg::PH_DONE) begin
			nxt = walk_pos + 17'd1;
			walk_pos = nxt;
			case (walk_phase)
				drpk_pkg::PH_SEQ_LEN, drpk_pkg::PH_SEQ_EXT: begin
					r = (walk_phase == drpk_pkg::PH_SEQ_LEN) ? len_head(b) : len_tail(b);
					if (r == LEN_BAD) begin
						res.st = drpk_pkg::ST_BAD_LEN;
						hit = 1'b1;
					end else if (r == LEN_DONE) begin
						walk_phase = drpk_pkg::PH_MOD_TAG;
					end else begin
						walk_phase = drpk_pkg::PH_SEQ_EXT;
					end
				end
				drpk_pkg::PH_MOD_TAG: begin
					if (b != drpk_pkg::TagInteger) begin
						res.st = drpk_pkg::ST_BAD_TAG;
						hit = 1'b1;
					end else begin
						walk_phase = drpk_pkg::PH_MOD_LEN;
					end
				end
				drpk_pkg::PH_MOD_LEN, drpk_pkg::PH_MOD_EXT: begin
					r = (walk_phase == drpk_pkg::PH_MOD_LEN) ? len_head(b) : len_tail(b);
					if (r == LEN_BAD) begin
						res.st = drpk_pkg::ST_BAD_LEN;
						hit = 1'b1;
					end else if (r == LEN_MORE) begin
						walk_phase = drpk_pkg::PH_MOD_EXT;
					end else begin
						mod_off = nxt;
						mod_len = len_acc;
						skip_left = len_acc;
						if (len_acc == 16'd0)
							walk_phase = drpk_pkg::PH_EXP_TAG;
						else
							walk_phase = drpk_pkg::PH_MOD_SKIP;
					end
				end
				drpk_pkg::PH_MOD_SKIP: begin
					skip_left = skip_left - 16'd1;
					if (skip_left == 16'd0)
						walk_phase = drpk_pkg::PH_EXP_TAG;
				end
				drpk_pkg::PH_EXP_TAG: begin
					if (b != drpk_pkg::TagInteger) begin
						res.st = drpk_pkg::ST_BAD_TAG;
						hit = 1'b1;
					end else begin
						walk_phase = drpk_pkg::PH_EXP_LEN;
					end
				end
				drpk_pkg::PH_EXP_LEN, drpk_pkg::PH_EXP_EXT: begin
					r = (walk_phase == drpk_pkg::PH_EXP_LEN) ? len_head(b) : len_tail(b);
					if (r == LEN_BAD) begin
						res.st = drpk_pkg::ST_BAD_LEN;
						hit = 1'b1;
					end else if (r == LEN_MORE) begin
						walk_phase = drpk_pkg::PH_EXP_EXT;
					end else begin
						hit = 1'b1;
						if (sel_shadow) begin
							res.off = mod_off;
							res.len = mod_len;
						end else begin
							res.off = nxt;
							res.len = len_acc;
						end
					end
				end
				default: walk_phase = drpk_pkg::PH_DONE;
			endcase
		end
		if (hit)
			walk_phase = drpk_pkg::PH_DONE;
		return hit;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic f, input logic hold);
		key_byte_t kb;
		kb.b = b;
		kb.f = f;
		kb.drain = hold;
		pend_q.push_back(kb);
		items_sent++;
	endtask

	task automatic send_blob(input logic hold);
		foreach (blob_q[i])
			push_byte(blob_q[i], i == 0, hold && i == 0);
	endtask

	task automatic put_len(input int unsigned val);
		int unsigned form;
		form = $urandom_range(0, 2);
		if (val > 255)
			form = 2;
		else if (val > 127 && form == 0)
			form = 1;
		if (form == 0) begin
			blob_q.push_back(8'(val));
		end else if (form == 1) begin
			blob_q.push_back(drpk_pkg::LenOneByte);
			blob_q.push_back(8'(val));
		end else begin
			blob_q.push_back(drpk_pkg::LenTwoBytes);
			blob_q.push_back(8'(val >> 8));
			blob_q.push_back(8'(val));
		end
	endtask

	task automatic build_key();
		int unsigned pick;
		int unsigned mlen;
		blob_q.delete();
		marks[0] = 0;
		blob_q.push_back(drpk_pkg::TagSequence);
		marks[1] = 1;
		if ($urandom_range(0, 3) == 0)
			put_len($urandom_range(0, 65535));
		else
			put_len($urandom_range(0, 300));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			mlen = 0;
		else if (pick < 89)
			mlen = $urandom_range(1, 12);
		else if (pick < 98)
			mlen = $urandom_range(13, 160);
		else
			mlen = $urandom_range(256, 520);
		marks[2] = blob_q.size();
		blob_q.push_back(drpk_pkg::TagInteger);
		marks[3] = blob_q.size();
		put_len(mlen);
		repeat (mlen)
			blob_q.push_back(8'($urandom));
		marks[4] = blob_q.size();
		blob_q.push_back(drpk_pkg::TagInteger);
		marks[5] = blob_q.size();
		if ($urandom_range(0, 3) == 0)
			put_len($urandom_range(0, 65535));
		else
			put_len($urandom_range(0, 300));
	endtask

	task automatic break_key();
		int unsigned j;
		logic [7:0] v;
		j = $urandom_range(0, 5);
		if (j % 2 == 0) begin
			blob_q[marks[j]] = 8'($urandom);
		end else begin
			v = 8'($urandom_range(8'h80, 8'hFF));
			if (v == drpk_pkg::LenOneByte || v == drpk_pkg::LenTwoBytes)
				v = LenIndefinite;
			blob_q[marks[j]] = v;
		end
	endtask

	task automatic write_reg(input drpk_pkg::reg_index_t idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == drpk_pkg::REG_PART_SELECT)
			sel_shadow = v[0];
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || in_valid || located_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		key_byte_t kb;
		bit go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			go = pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
			if (go && pend_q[0].drain && (pending_cnt != 0 || (in_valid && in_ready)))
				go = 1'b0;
			if (go) begin
				kb = pend_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= kb.b;
				first <= kb.f;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		loc_result_t want;
		loc_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.st = drpk_pkg::status_t'(status);
				got.off = part_offset;
				got.len = part_length;
				if (located_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected transfer: status %0d offset %0d length %0d",
							got.st, got.off, got.len);
				end else begin
					want = located_q.pop_front();
					if (got.st != want.st || got.off != want.off || got.len != want.len) begin
						err_count++;
						if (err_count <= 10)
							$display("mismatch exp/act: st %0d/%0d off %0d/%0d len %0d/%0d",
								want.st, got.st, want.off, got.off, want.len, got.len);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (locate_step(data_byte, first, want))
					located_q.push_back(want);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("der_rsa_pubkey_locator_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
		pending_cnt <= located_q.size();
		out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
	end

	initial begin
		int unsigned p;
		int unsigned goal;
		int unsigned kind;
		int unsigned cut;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray byte before any blob
		push_byte(8'h00, 1'b0, 1'b0);
		// empty modulus, one-byte long form
		blob_q = '{drpk_pkg::TagSequence, drpk_pkg::LenOneByte, 8'h05, drpk_pkg::TagInteger,
			8'h00, drpk_pkg::TagInteger, 8'h01};
		send_blob(1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		// restart mid-blob, then a two-byte exponent length of all ones
		blob_q = '{drpk_pkg::TagSequence, drpk_pkg::TagInteger};
		send_blob(1'b0);
		blob_q = '{drpk_pkg::TagSequence, 8'h05, drpk_pkg::TagInteger, 8'h01, 8'hFF,
			drpk_pkg::TagInteger, drpk_pkg::LenTwoBytes, 8'hFF, 8'hFF};
		send_blob(1'b0);
		// hold until every earlier result has been taken
		blob_q = '{8'h31};
		send_blob(1'b1);
		blob_q = '{drpk_pkg::TagSequence, LenIndefinite};
		send_blob(1'b0);
		blob_q = '{drpk_pkg::TagSequence, 8'h00, drpk_pkg::TagInteger, 8'h83};
		send_blob(1'b0);

		for (p = 0; p < 8; p++) begin
			wait_idle();
			write_reg(drpk_pkg::REG_PART_SELECT,
				{$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, ~p[0]});
			@(negedge clk);
			case (p / 2)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 55; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 55; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			goal = items_sent + PhaseItems;
			while (items_sent < goal) begin
				kind = $urandom_range(0, 99);
				if (kind < 12) begin
					repeat ($urandom_range(1, 6))
						push_byte(8'($urandom), $urandom_range(0, 5) == 0, 1'b0);
				end else begin
					build_key();
					if (kind < 22) begin
						break_key();
					end else if (kind < 28) begin
						cut = $urandom_range(1, blob_q.size() - 1);
						while (blob_q.size() > cut)
							void'(blob_q.pop_back());
					end
					send_blob((p == 4 && items_sent + PhaseItems == goal) ||
						$urandom_range(0, 29) == 0);
					if (kind >= 28)
						repeat ($urandom_range(0, 3))
							push_byte(8'($urandom), 1'b0, 1'b0);
				end
			end
		end
		wait_idle();
		if (err_count == 0)
			$display("der_rsa_pubkey_locator_tb OK");
		else
			$display("der_rsa_pubkey_locator_tb NOT OK");
		$finish;
	end

endmodule
